// File: rtl/core/assert_macros.svh
// assertion macros shared by the framer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DLF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DLF_ASSERT_NEVER(name, cond, msg) \
  `DLF_ASSERT(name, !(cond), msg)

`endif

// File: rtl/core/dlf_pkg.sv
// shared types and constants of the delimiter line framer
package dlf_pkg;

  // width of fill count and message length (up to depth plus one)
  localparam int unsigned CNT_W = 7;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] DELIM_NL = 8'h0A;

  localparam logic [2:0]  DELIM_LEN_RST = 3'd1;
  localparam logic [31:0] DELIM_BYTES_RST = 32'h0000_000A;
  localparam logic [6:0]  LENGTH_LIMIT_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_LEN    = 3'd0,
    CFG_DELIM_BYTES  = 3'd1,
    CFG_KEEP_DELIM   = 3'd2,
    CFG_LENGTH_LIMIT = 3'd3
  } cfg_idx_e;

  // message start request from the ingest side to the emitter
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
  } emit_cmd_t;

endpackage

// File: rtl/core/dlf_in_if.sv
// input channel: one command or stream byte per beat
interface dlf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// File: rtl/core/dlf_out_if.sv
// output channel: one message byte per beat
interface dlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       msg_last;
  logic       msg_empty;

  modport source (output valid, output msg_byte, output msg_last, output msg_empty,
                  input ready);
  modport sink   (input valid, input msg_byte, input msg_last, input msg_empty,
                  output ready);
endinterface

// File: rtl/core/dlf_store.sv
// message byte store: one write port, one read port, registered read data
module dlf_store #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] waddr_i,
  input  logic [7:0]                      wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] raddr_i,
  output logic [7:0]                      rdata_o
);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/dlf_emit.sv
// message emitter: reads the store into the output register, one byte a cycle while that register is free
`include "assert_macros.svh"

module dlf_emit #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dlf_pkg::emit_cmd_t              cmd_i,
  output logic                            busy_o,
  output logic                            re_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] raddr_o,
  input  logic [7:0]                      rdata_i,
  dlf_out_if.source                       out_o
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic [dlf_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [AddrW-1:0]          idx_q, idx_d;
  logic                      pend_q, pend_d;
  logic                      pend_last_q, pend_last_d;
  logic                      empty_pend_q, empty_pend_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic                      out_last_q, out_last_d;
  logic                      out_empty_q, out_empty_d;

  logic out_free, move, emit_empty, issue;

  assign out_free   = !out_valid_q || out_o.ready;
  assign move       = pend_q && out_free;
  assign emit_empty = empty_pend_q && out_free;
  assign issue      = (rem_q != '0) && (!pend_q || move);

  assign busy_o  = (rem_q != '0) || pend_q || empty_pend_q;
  assign re_o    = issue;
  assign raddr_o = idx_q;

  always_comb begin
    rem_d        = rem_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    empty_pend_d = empty_pend_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;

    if (issue) begin
      rem_d       = rem_q - dlf_pkg::CNT_W'(1);
      idx_d       = idx_q + AddrW'(1);
      pend_d      = 1'b1;
      pend_last_d = (rem_q == dlf_pkg::CNT_W'(1));
    end else if (move) begin
      pend_d = 1'b0;
    end

    if (emit_empty) begin
      empty_pend_d = 1'b0;
    end

    if (cmd_i.start) begin
      rem_d        = cmd_i.len;
      idx_d        = '0;
      empty_pend_d = (cmd_i.len == '0);
    end

    // output register: store data, empty marker or drain
    if (move) begin
      out_valid_d = 1'b1;
      out_byte_d  = rdata_i;
      out_last_d  = pend_last_q;
      out_empty_d = 1'b0;
    end else if (emit_empty) begin
      out_valid_d = 1'b1;
      out_byte_d  = '0;
      out_last_d  = 1'b1;
      out_empty_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q        <= '0;
      pend_q       <= 1'b0;
      empty_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rem_q        <= rem_d;
      pend_q       <= pend_d;
      empty_pend_q <= empty_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pend_last_q <= pend_last_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.msg_byte  = out_byte_q;
  assign out_o.msg_last  = out_last_q;
  assign out_o.msg_empty = out_empty_q;

  `DLF_ASSERT(a_start_when_idle, cmd_i.start |-> !busy_o, "message start while emitter busy")
  `DLF_ASSERT_NEVER(a_pend_excl, pend_q && empty_pend_q, "read pending with empty marker")
  `DLF_ASSERT(a_empty_is_last, out_valid_q && out_empty_q |-> out_last_q, "empty beat not last")
  `DLF_ASSERT(a_rem_steps, issue && !cmd_i.start |=> rem_q == $past(rem_q) - 1'b1,
              "remaining count did not step on a read")

endmodule

// File: rtl/core/delimiter_line_framer_core.sv
// top level of the delimiter line framer: ingest, delimiter match, store and emitter
//
//   channel  dir  beat contents                    handshake
//   in_i     in   cmd, data_byte                   valid/ready
//   out_o    out  msg_byte, msg_last, msg_empty    valid/ready
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i  write strobe, no wait
//
// flow: one input beat a cycle while the emitter is idle; a match within
//   the limit starts the emitter, and input stalls until the single store
//   read port has fetched every payload byte and the last one, or the empty
//   marker, is in the output register; output beats go one per cycle if ready
// reset: clears configuration, fill count, window and emitter; the store is
//   not cleared, only bytes written since the last clear are ever read
// stalls: a held output beat blocks input only while the emitter still has
//   payload bytes or the empty marker to pass to the output register; the emitter
//   keeps one fetched byte in the store read register behind the output register
module delimiter_line_framer_core #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned MAX_DELIM    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  dlf_in_if.sink                              in_i,
  dlf_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dlf_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);
  localparam int unsigned WinW  = 8 * MAX_DELIM;
  localparam int unsigned CntW  = dlf_pkg::CNT_W;

  // configuration registers
  logic [2:0]  delim_len_q;
  logic [31:0] delim_bytes_q;
  logic        keep_delim_q;
  logic [6:0]  length_limit_q;

  // message state: fill count and window of the newest held bytes
  logic [CntW-1:0] fill_q, fill_d;
  logic [WinW-1:0] win_q, win_d;

  logic            accept, push;
  logic [2:0]      dlen;
  logic [31:0]     dpat;
  logic [CntW-1:0] limit;
  logic [CntW-1:0] count;
  logic [WinW-1:0] win_new;
  logic [MAX_DELIM-1:0] match_k;
  logic            delim_hit;
  logic            fits;
  logic [CntW-1:0] payload;

  dlf_pkg::emit_cmd_t emit_cmd;
  logic               emit_busy;
  logic               store_re;
  logic [AddrW-1:0]   store_raddr;
  logic [7:0]         store_rdata;

  // config writes, out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_len_q    <= dlf_pkg::DELIM_LEN_RST;
      delim_bytes_q  <= dlf_pkg::DELIM_BYTES_RST;
      keep_delim_q   <= 1'b0;
      length_limit_q <= dlf_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (dlf_pkg::cfg_idx_e'(cfg_idx_i))
        dlf_pkg::CFG_DELIM_LEN:    delim_len_q    <= cfg_data_i[2:0];
        dlf_pkg::CFG_DELIM_BYTES:  delim_bytes_q  <= cfg_data_i[31:0];
        dlf_pkg::CFG_KEEP_DELIM:   keep_delim_q   <= cfg_data_i[0];
        dlf_pkg::CFG_LENGTH_LIMIT: length_limit_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // input is taken whenever the emitter is not busy with the previous message
  assign in_i.ready = !emit_busy;
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && !in_i.cmd;

  // effective delimiter: length zero means a lone newline, long ones saturate
  always_comb begin
    if (delim_len_q == '0) begin
      dlen = 3'd1;
      dpat = {24'd0, dlf_pkg::DELIM_NL};
    end else if (delim_len_q > 3'(MAX_DELIM)) begin
      dlen = 3'(MAX_DELIM);
      dpat = delim_bytes_q;
    end else begin
      dlen = delim_len_q;
      dpat = delim_bytes_q;
    end
  end

  assign limit = (length_limit_q > 7'(BUFFER_DEPTH)) ? CntW'(BUFFER_DEPTH)
                                                     : CntW'(length_limit_q);

  assign count   = fill_q + CntW'(1);
  assign win_new = (win_q << 8) | WinW'(in_i.data_byte);

  // one compare per delimiter length, newest byte against the last pattern byte
  always_comb begin
    match_k = '0;
    for (int k = 0; k < MAX_DELIM; k++) begin
      match_k[k] = 1'b1;
      for (int i = 0; i <= k; i++) begin
        if (dpat[8*i +: 8] != win_new[8*(k-i) +: 8]) begin
          match_k[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    delim_hit = 1'b0;
    for (int k = 0; k < MAX_DELIM; k++) begin
      if (dlen == 3'(k + 1) && match_k[k]) begin
        delim_hit = 1'b1;
      end
    end
    // the whole delimiter must lie in bytes held since the last clear
    if (8'(count) < 8'(dlen)) begin
      delim_hit = 1'b0;
    end
  end

  assign fits    = (count <= limit);
  assign payload = keep_delim_q ? count : count - CntW'(dlen);

  always_comb begin
    fill_d = fill_q;
    win_d  = win_q;
    if (accept) begin
      if (in_i.cmd || !fits || delim_hit) begin
        fill_d = '0;
        win_d  = '0;
      end else begin
        fill_d = count;
        win_d  = win_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      win_q  <= '0;
    end else begin
      fill_q <= fill_d;
      win_q  <= win_d;
    end
  end

  assign emit_cmd.start = push && fits && delim_hit;
  assign emit_cmd.len   = payload;

  // every byte within the limit is stored at its place in the message
  dlf_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push && fits),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  dlf_emit #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (emit_cmd),
    .busy_o  (emit_busy),
    .re_o    (store_re),
    .raddr_o (store_raddr),
    .rdata_i (store_rdata),
    .out_o   (out_o)
  );

endmodule

// File: tb/sv/tb_delimiter_line_framer_core.sv
// self-checking testbench for the delimiter line framer core
module tb_delimiter_line_framer_core;

  // geometry of the instance under test (rtl defaults)
  localparam int unsigned DEPTH        = 64;
  localparam int unsigned MAX_DL       = 4;
  // idle odds per side, in percent
  localparam int unsigned IDLE_PCT     = 38;
  // items per random register setting, and number of settings
  localparam int unsigned PHASE_ITEMS  = 38;
  localparam int unsigned PHASE_COUNT  = 10;
  // quiet cycles allowed after the last handshake before a reconfig or the end
  localparam int unsigned SETTLE_CYCLES = 16;
  // cycles with no handshake at all before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 2000;
  // an index past the register map, writes to it must be ignored
  localparam logic [dlf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
  // carriage return, used to build delimiters with repeated bytes
  localparam logic [7:0] CR_BYTE = 8'h0D;

  typedef struct packed {
    logic       clr;
    logic [7:0] data;
  } feed_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } msg_beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [dlf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dlf_pkg::CFG_W-1:0]     cfg_data_i;

  dlf_in_if  in_bus ();
  dlf_out_if out_bus ();

  delimiter_line_framer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // stimulus waiting to be driven, and message beats the framer still owes us
  feed_beat_t feed_q[$];
  msg_beat_t  due_q[$];

  // framer model state: configuration as written, held bytes and the byte window
  logic [2:0]  cfg_delim_len;
  logic [31:0] cfg_delim_bytes;
  logic        cfg_keep_delim;
  logic [6:0]  cfg_length_limit;
  logic [7:0]  held_store [DEPTH];
  int unsigned held_count;
  logic [23:0] tail_window;

  // bookkeeping
  bit          no_idle;
  bit          run_done;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned queued_items;
  int unsigned beats_in, clears_in, beats_out, msgs_out, empties_out, reg_writes;
  feed_beat_t  drive_beat;
  msg_beat_t   got_beat, want_beat;

  function automatic void drop_held();
    held_count  = 0;
    tail_window = '0;
  endfunction

  // advance the framer model by one input beat, queue any message beats it releases
  function automatic void ingest_beat(input logic clr, input logic [7:0] b);
    int unsigned dlen, limit, count, payload;
    logic [31:0] pat, window;
    bit          hit;
    msg_beat_t   mb;
    if (clr) begin
      // clear ignores the data byte entirely
      drop_held();
      return;
    end
    // a zero length falls back to a single newline, larger lengths saturate
    if (cfg_delim_len == 3'd0) begin
      dlen = 1;
      pat  = {24'h0, dlf_pkg::DELIM_NL};
    end else begin
      dlen = (cfg_delim_len > MAX_DL) ? MAX_DL : cfg_delim_len;
      pat  = cfg_delim_bytes;
    end
    limit  = (cfg_length_limit > DEPTH) ? DEPTH : cfg_length_limit;
    count  = held_count + 1;
    window = {tail_window, b};
    // first delimiter byte lines up with the oldest byte of the window slice
    hit = (count >= dlen);
    for (int i = 0; i < dlen; i++) begin
      if (pat[8*i +: 8] != window[8*(dlen-1-i) +: 8]) hit = 1'b0;
    end
    if (!hit) begin
      if (count > limit) begin
        drop_held();
      end else begin
        held_store[count-1] = b;
        held_count          = count;
        tail_window         = window[23:0];
      end
      return;
    end
    // completed delimiter but the message is too long: dropped silently
    if (count > limit) begin
      drop_held();
      return;
    end
    held_store[count-1] = b;
    payload = cfg_keep_delim ? count : count - dlen;
    drop_held();
    if (payload == 0) begin
      mb.data  = 8'h00;
      mb.last  = 1'b1;
      mb.empty = 1'b1;
      due_q.push_back(mb);
    end else begin
      for (int i = 0; i < payload; i++) begin
        mb.data  = held_store[i];
        mb.last  = (i + 1 == payload);
        mb.empty = 1'b0;
        due_q.push_back(mb);
      end
    end
  endfunction

  // source side: hold a beat until taken, then maybe idle, then offer the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (feed_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        drive_beat        = feed_q.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.cmd       <= drive_beat.clr;
        in_bus.data_byte <= drive_beat.data;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // sink side: random back-pressure unless in the no-idle stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor: tracks register writes, feeds accepted input beats to the model,
  // checks each accepted output beat against the oldest one owed
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_delim_len    = dlf_pkg::DELIM_LEN_RST;
      cfg_delim_bytes  = dlf_pkg::DELIM_BYTES_RST;
      cfg_keep_delim   = 1'b0;
      cfg_length_limit = dlf_pkg::LENGTH_LIMIT_RST;
      drop_held();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_we_i) begin
        quiet_cycles = 0;
        case (cfg_idx_i)
          dlf_pkg::CFG_DELIM_LEN:    cfg_delim_len    = cfg_data_i[2:0];
          dlf_pkg::CFG_DELIM_BYTES:  cfg_delim_bytes  = cfg_data_i;
          dlf_pkg::CFG_KEEP_DELIM:   cfg_keep_delim   = cfg_data_i[0];
          dlf_pkg::CFG_LENGTH_LIMIT: cfg_length_limit = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        quiet_cycles = 0;
        beats_in++;
        if (in_bus.cmd) clears_in++;
        ingest_beat(in_bus.cmd, in_bus.data_byte);
      end
      if (out_bus.valid && out_bus.ready) begin
        quiet_cycles   = 0;
        got_beat.data  = out_bus.msg_byte;
        got_beat.last  = out_bus.msg_last;
        got_beat.empty = out_bus.msg_empty;
        beats_out++;
        if (got_beat.last === 1'b1) msgs_out++;
        if (got_beat.empty === 1'b1) empties_out++;
        if (due_q.size() == 0) begin
          $display("%0t: message beat with nothing owed: byte %02h last %b empty %b",
                   $time, got_beat.data, got_beat.last, got_beat.empty);
          errors++;
        end else begin
          want_beat = due_q.pop_front();
          if (got_beat !== want_beat) begin
            $display("%0t: mismatch: expected byte/last/empty %02h/%b/%b, got %02h/%b/%b",
                     $time, want_beat.data, want_beat.last, want_beat.empty,
                     got_beat.data, got_beat.last, got_beat.empty);
            errors++;
          end
        end
      end
    end
  end

  task automatic queue_beat(input logic clr, input logic [7:0] b);
    feed_beat_t fb;
    fb.clr  = clr;
    fb.data = b;
    feed_q.push_back(fb);
    queued_items++;
  endtask

  // one strobe per register write, never two writes on back-to-back edges
  task automatic write_reg(input logic [dlf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlf_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_writes++;
  endtask

  // wait for every beat to go in and every owed beat to come out, then let the
  // ingest side settle so a register write cannot land mid-operation; checked
  // at the falling edge so the driver and monitor have both settled
  task automatic drain();
    @(negedge clk_i);
    while (feed_q.size() != 0 || in_bus.valid || due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // byte alphabet biased toward values that tend to appear in delimiters
  function automatic logic [7:0] pick_sym();
    logic [7:0] sym;
    case ($urandom_range(0, 3))
      0:       sym = CR_BYTE;
      1:       sym = dlf_pkg::DELIM_NL;
      2:       sym = 8'hFF;
      default: sym = 8'($urandom_range(0, 255));
    endcase
    return sym;
  endfunction

  // one register setting followed by mostly well-formed framed messages
  task automatic random_phase(input int unsigned phase);
    logic [2:0]  len_val;
    logic [6:0]  limit_val;
    logic        keep_val;
    logic [31:0] pat, eff_pat, junk;
    int unsigned dlen, lim, plen, k, pos, target, kind;
    case (phase)
      0: begin len_val = 3'd0; limit_val = 7'd127; end
      1: begin len_val = 3'd4; limit_val = 7'd12;  end
      2: begin len_val = 3'd7; limit_val = 7'd64;  end
      3: begin len_val = 3'd1; limit_val = 7'd1;   end
      4: begin len_val = 3'd2; limit_val = 7'd0;   end
      default: begin
        len_val   = 3'($urandom_range(0, 7));
        limit_val = 7'($urandom_range(2, 24));
      end
    endcase
    keep_val = 1'($urandom_range(0, 1));
    // half the delimiter bytes are drawn from a biased alphabet so that the payload
    // produces partial and overlapping matches
    for (int i = 0; i < 4; i++) begin
      pat[8*i +: 8] = $urandom_range(0, 1) ? pick_sym() : 8'($urandom_range(0, 255));
    end
    // unused upper data bits carry noise, the block must mask them off
    junk = $urandom();
    write_reg(dlf_pkg::CFG_DELIM_LEN,    {junk[31:3], len_val});
    write_reg(dlf_pkg::CFG_DELIM_BYTES,  pat);
    write_reg(dlf_pkg::CFG_KEEP_DELIM,   {junk[31:1], keep_val});
    write_reg(dlf_pkg::CFG_LENGTH_LIMIT, {junk[31:7], limit_val});

    if (len_val == 3'd0) begin
      dlen    = 1;
      eff_pat = {24'h0, dlf_pkg::DELIM_NL};
    end else begin
      dlen    = (len_val > MAX_DL) ? MAX_DL : len_val;
      eff_pat = pat;
    end
    lim = (limit_val > DEPTH) ? DEPTH : limit_val;

    @(negedge clk_i);
    no_idle = (phase == 2);
    target  = queued_items + PHASE_ITEMS;
    while (queued_items < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        // framed message: payload then the full delimiter; now and then right
        // at the length limit or one byte past it
        if ($urandom_range(0, 7) == 0 && lim > dlen) begin
          plen = $urandom_range(lim - dlen, lim - dlen + 1);
        end else begin
          plen = $urandom_range(0, 6);
        end
        for (int j = 0; j < plen; j++) begin
          if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, dlen - 1);
            queue_beat(1'b0, eff_pat[8*pos +: 8]);
          end else begin
            queue_beat(1'b0, 8'($urandom_range(0, 255)));
          end
        end
        for (int j = 0; j < dlen; j++) queue_beat(1'b0, eff_pat[8*j +: 8]);
      end else if (kind < 15) begin
        queue_beat(1'b1, 8'($urandom_range(0, 255)));
      end else if (kind < 17) begin
        // delimiter cut in two by a clear, the tail alone must not match
        k = (dlen > 1) ? $urandom_range(1, dlen - 1) : 0;
        for (int j = 0; j < k; j++) queue_beat(1'b0, eff_pat[8*j +: 8]);
        queue_beat(1'b1, 8'($urandom_range(0, 255)));
        for (int j = k; j < dlen; j++) queue_beat(1'b0, eff_pat[8*j +: 8]);
      end else begin
        repeat ($urandom_range(1, 3)) queue_beat(1'b0, pick_sym());
      end
    end
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.cmd        = 1'b0;
    in_bus.data_byte  = 8'h00;
    out_bus.ready     = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = dlf_pkg::CFG_DELIM_LEN;
    cfg_data_i        = '0;
    no_idle           = 1'b0;
    run_done          = 1'b0;
    errors            = 0;
    queued_items      = 0;
    beats_in          = 0;
    clears_in         = 0;
    beats_out         = 0;
    msgs_out          = 0;
    empties_out       = 0;
    reg_writes        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: newline delimiter, delimiter stripped, limit 64
    @(negedge clk_i);
    queue_beat(1'b0, 8'h00);
    queue_beat(1'b0, 8'hFF);
    queue_beat(1'b0, dlf_pkg::DELIM_NL);     // two byte message, both byte extremes
    queue_beat(1'b0, dlf_pkg::DELIM_NL);     // empty payload
    queue_beat(1'b0, 8'h41);
    queue_beat(1'b1, dlf_pkg::DELIM_NL);     // clear, its data byte must be ignored
    queue_beat(1'b0, dlf_pkg::DELIM_NL);     // empty again since the clear dropped the byte
    drain();

    // stray index, zero length means newline, delimiter kept, tight limit
    write_reg(CFG_IDX_SPARE, $urandom());
    write_reg(dlf_pkg::CFG_DELIM_LEN, 32'hFFFF_FFF8);
    write_reg(dlf_pkg::CFG_DELIM_BYTES, {16'h0000, CR_BYTE, dlf_pkg::DELIM_NL});
    write_reg(dlf_pkg::CFG_KEEP_DELIM, 32'h0000_0001);
    write_reg(dlf_pkg::CFG_LENGTH_LIMIT, 32'h0000_0003);
    @(negedge clk_i);
    queue_beat(1'b0, 8'h31);
    queue_beat(1'b0, dlf_pkg::DELIM_NL);     // kept delimiter, two beats out
    queue_beat(1'b0, 8'h31);
    queue_beat(1'b0, 8'h32);
    queue_beat(1'b0, 8'h33);
    queue_beat(1'b0, dlf_pkg::DELIM_NL);     // match one past the limit, dropped
    drain();

    // oversize length saturates to four bytes, zero limit swallows everything
    write_reg(dlf_pkg::CFG_DELIM_LEN, 32'h0000_0007);
    write_reg(dlf_pkg::CFG_DELIM_BYTES, 32'h4443_4241);
    write_reg(dlf_pkg::CFG_KEEP_DELIM, 32'h0000_0000);
    write_reg(dlf_pkg::CFG_LENGTH_LIMIT, 32'h0000_0000);
    @(negedge clk_i);
    queue_beat(1'b0, 8'h41);
    drain();
    // limit past the store depth clamps to the depth
    write_reg(dlf_pkg::CFG_LENGTH_LIMIT, 32'h0000_007F);
    @(negedge clk_i);
    queue_beat(1'b0, 8'h41);
    queue_beat(1'b0, 8'h42);
    queue_beat(1'b1, 8'h00);        // clear splits the delimiter
    queue_beat(1'b0, 8'h43);
    queue_beat(1'b0, 8'h44);        // tail alone does not match
    queue_beat(1'b1, 8'hFF);
    queue_beat(1'b0, 8'h41);
    queue_beat(1'b0, 8'h42);
    queue_beat(1'b0, 8'h43);
    queue_beat(1'b0, 8'h44);        // whole delimiter right after a clear, empty
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) random_phase(p);

    run_done = 1'b1;
    $display("stimulus: %0d input beats (%0d clears) across %0d register writes",
             beats_in, clears_in, reg_writes);
    $display("checked: %0d message beats in %0d messages, %0d of them empty",
             beats_out, msgs_out, empties_out);
    if (errors == 0 && due_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (due_q.size() != 0) begin
        $display("%0t: %0d message beats never arrived", $time, due_q.size());
      end
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: a long stretch without any handshake means the block is stuck
  initial begin
    while (!run_done && quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    if (!run_done) begin
      $display("%0t: no beat moved for %0d cycles, %0d message beats still owed",
               $time, QUIET_LIMIT, due_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
